// ----- rtl/mpmc_pkg.sv -----
// ----------------------------------------------------------------------------
// mpmc_pkg: shared types and codes for the multi-pattern match counter
// Item structs on the command and result ports, and the opcode values.
// ----------------------------------------------------------------------------
`default_nettype none

package mpmc_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned SYMBOL_W = 5;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned TOTAL_W  = 32;

  localparam logic [OPCODE_W-1:0] OP_PAT_SYM  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PAT_END  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_BUILD    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_TEXT_SYM = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_TEXT_END = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd5;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [SYMBOL_W-1:0] symbol;
  } mpmc_in_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] match_count;
    logic               overflow;
  } mpmc_out_t;

endpackage

`default_nettype wire

// ----- rtl/multi_pattern_match_counter.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_match_counter
// Aho-Corasick engine: builds a trie from pattern items, links it breadth
// first, then counts pattern occurrences over text items.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  command   in   start & !busy    item   (opcode, symbol)
//  result    out  done, one cycle  result (match_count, overflow)
//
//  Per item: a pattern symbol reads its transition, then follows or adds a
//  node; end pattern bumps the reached node's count; a text symbol does a
//  transition read, then a count read, both on registered-read RAMs; end text
//  strobes the result in the next cycle. Build walks the trie with one
//  transition-RAM access per step.
//  After reset and after a clear item, a clearing pass zeroes the
//  transition and count RAMs; busy stays high throughout.
//  Reset is synchronous, active high. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_match_counter #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned ALPHABET  = 26
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mpmc_pkg::mpmc_in_t  item,
  output logic                done,
  output mpmc_pkg::mpmc_out_t result
);
  import mpmc_pkg::*;

  localparam int unsigned TDEPTH = MAX_NODES * ALPHABET;
  localparam int unsigned AW     = $clog2(TDEPTH);
  localparam int unsigned NW     = $clog2(MAX_NODES);
  localparam int unsigned SW     = $clog2(ALPHABET);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_P_CHK, S_E_INC, S_T_NX, S_T_ADD,
    S_B_R0, S_B_R1, S_B_NEXT, S_B_P, S_B_F, S_B_S0, S_B_S1, S_B_S2,
    S_B_S3, S_B_S4
  } state_t;

  state_t state;

  // Control registers
  logic [AW-1:0]   clr_idx;
  logic [NW:0]     nodes_used;
  logic [NW-1:0]   cur;
  logic [TOTAL_W-1:0] total;
  logic            built;
  logic            ovf;
  logic            dropped;
  logic [NW:0]     head;
  logic [NW:0]     tail;
  logic [SW-1:0]   sidx;
  // Payload registers
  logic [AW-1:0]   taddr;
  logic [AW-1:0]   prow;
  logic [AW-1:0]   frow;
  logic [NW-1:0]   qn;
  logic [COUNT_W-1:0] cvia;

  // RAMs
  logic [NW-1:0]      trans_mem [TDEPTH];
  logic [COUNT_W-1:0] count_mem [MAX_NODES];
  logic [NW-1:0]      fail_mem  [MAX_NODES];
  logic [NW-1:0]      queue_mem [MAX_NODES];

  logic [AW-1:0]      t_raddr, t_waddr;
  logic [NW-1:0]      t_wdata, t_rdata;
  logic               t_we;
  logic [NW-1:0]      c_raddr, c_waddr;
  logic [COUNT_W-1:0] c_wdata, c_rdata;
  logic               c_we;
  logic [NW-1:0]      f_raddr, f_waddr, f_wdata, f_rdata;
  logic               f_we;
  logic [NW-1:0]      q_rdata;
  logic               q_we;

  logic               acc;
  logic               sym_ok;
  logic [AW-1:0]      in_addr;
  logic               last_sym;
  logic [COUNT_W:0]   inc_sum;
  logic [COUNT_W:0]   via_sum;
  logic [TOTAL_W:0]   tot_sum;
  logic               enq;

  assign busy     = (state != S_IDLE);
  assign acc      = start && !busy;
  assign sym_ok   = {4'b0, item.symbol} < 9'(ALPHABET);
  assign in_addr  = AW'(cur) * AW'(ALPHABET) + AW'(item.symbol);
  assign last_sym = (sidx == SW'(ALPHABET - 1));
  assign inc_sum  = {1'b0, c_rdata} + (COUNT_W+1)'(1);
  assign via_sum  = {1'b0, c_rdata} + {1'b0, cvia};
  assign tot_sum  = {1'b0, total} + (TOTAL_W+1)'(c_rdata);
  // Root child found during the first level of the walk
  assign enq      = (t_rdata != '0) && (tail < (NW+1)'(MAX_NODES));

  // Address and write-enable selection for the four RAMs
  always_comb begin
    t_raddr = in_addr;
    t_we    = 1'b0;
    t_waddr = taddr;
    t_wdata = NW'(nodes_used);
    c_raddr = cur;
    c_we    = 1'b0;
    c_waddr = cur;
    c_wdata = inc_sum[COUNT_W] ? '1 : inc_sum[COUNT_W-1:0];
    f_raddr = q_rdata;
    f_we    = 1'b0;
    f_waddr = t_rdata;
    f_wdata = '0;
    q_we    = 1'b0;
    case (state)
      S_CLR: begin
        t_we    = 1'b1;
        t_waddr = clr_idx;
        t_wdata = '0;
        c_we    = (clr_idx < AW'(MAX_NODES));
        c_waddr = clr_idx[NW-1:0];
        c_wdata = '0;
      end
      S_P_CHK: begin
        t_we = (t_rdata == '0) && (nodes_used < (NW+1)'(MAX_NODES));
      end
      S_E_INC: begin
        c_we = 1'b1;
      end
      S_T_NX: begin
        c_raddr = t_rdata;
      end
      S_B_R0: begin
        t_raddr = AW'(sidx);
      end
      S_B_R1: begin
        f_we = enq;
        q_we = enq;
      end
      S_B_S0: begin
        t_raddr = prow + AW'(sidx);
      end
      S_B_S1: begin
        t_raddr = frow + AW'(sidx);
      end
      S_B_S2: begin
        // Existing child: link it and queue it; absent: borrow the link's edge
        c_raddr = t_rdata;
        f_waddr = qn;
        f_wdata = t_rdata;
        f_we    = (qn != '0);
        q_we    = (qn != '0) && (tail < (NW+1)'(MAX_NODES));
        t_we    = (qn == '0);
        t_waddr = prow + AW'(sidx);
        t_wdata = t_rdata;
      end
      S_B_S3: begin
        c_raddr = qn;
      end
      S_B_S4: begin
        c_we    = 1'b1;
        c_waddr = qn;
        c_wdata = via_sum[COUNT_W] ? '1 : via_sum[COUNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      trans_mem[t_waddr] <= t_wdata;
    end
    t_rdata <= trans_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      count_mem[c_waddr] <= c_wdata;
    end
    c_rdata <= count_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fail_mem[f_waddr] <= f_wdata;
    end
    f_rdata <= fail_mem[f_raddr];
  end

  // Queue write data is the child just read, at either walk level
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[tail[NW-1:0]] <= (state == S_B_R1) ? t_rdata : qn;
    end
    q_rdata <= queue_mem[head[NW-1:0]];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst || (acc && item.opcode == OP_CLEAR)) begin
      state      <= S_CLR;
      clr_idx    <= '0;
      nodes_used <= (NW+1)'(1);
      cur        <= '0;
      total      <= '0;
      built      <= 1'b0;
      ovf        <= 1'b0;
      dropped    <= 1'b0;
      head       <= '0;
      tail       <= '0;
      sidx       <= '0;
    end else begin
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == AW'(TDEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            taddr <= in_addr;
            case (item.opcode)
              OP_PAT_SYM: begin
                if (!built && !dropped && sym_ok) begin
                  state <= S_P_CHK;
                end
              end
              OP_PAT_END: begin
                if (!built) begin
                  if (!dropped && cur != '0) begin
                    state <= S_E_INC;
                  end else begin
                    cur     <= '0;
                    dropped <= 1'b0;
                  end
                end
              end
              OP_BUILD: begin
                if (!built) begin
                  state <= S_B_R0;
                  sidx  <= '0;
                  head  <= '0;
                  tail  <= '0;
                end
              end
              OP_TEXT_SYM: begin
                if (built && sym_ok) begin
                  state <= S_T_NX;
                end
              end
              OP_TEXT_END: begin
                if (built) begin
                  done               <= 1'b1;
                  result.match_count <= total;
                  result.overflow    <= ovf;
                  total              <= '0;
                  cur                <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_P_CHK: begin
          state <= S_IDLE;
          if (t_rdata != '0) begin
            cur <= t_rdata;
          end else if (nodes_used >= (NW+1)'(MAX_NODES)) begin
            ovf     <= 1'b1;
            dropped <= 1'b1;
          end else begin
            cur        <= NW'(nodes_used);
            nodes_used <= nodes_used + (NW+1)'(1);
          end
        end
        S_E_INC: begin
          state   <= S_IDLE;
          cur     <= '0;
          dropped <= 1'b0;
        end
        S_T_NX: begin
          cur   <= t_rdata;
          state <= S_T_ADD;
        end
        S_T_ADD: begin
          total <= tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
          state <= S_IDLE;
        end
        S_B_R0: begin
          state <= S_B_R1;
        end
        S_B_R1: begin
          if (enq) begin
            tail <= tail + (NW+1)'(1);
          end
          if (last_sym) begin
            state <= S_B_NEXT;
          end else begin
            sidx  <= sidx + SW'(1);
            state <= S_B_R0;
          end
        end
        S_B_NEXT: begin
          if (head < tail) begin
            head  <= head + (NW+1)'(1);
            state <= S_B_P;
          end else begin
            built   <= 1'b1;
            cur     <= '0;
            total   <= '0;
            dropped <= 1'b0;
            state   <= S_IDLE;
          end
        end
        S_B_P: begin
          prow  <= AW'(q_rdata) * AW'(ALPHABET);
          state <= S_B_F;
        end
        S_B_F: begin
          frow  <= AW'(f_rdata) * AW'(ALPHABET);
          sidx  <= '0;
          state <= S_B_S0;
        end
        S_B_S0: begin
          state <= S_B_S1;
        end
        S_B_S1: begin
          qn    <= t_rdata;
          state <= S_B_S2;
        end
        S_B_S2: begin
          if (qn != '0) begin
            if (tail < (NW+1)'(MAX_NODES)) begin
              tail <= tail + (NW+1)'(1);
            end
            state <= S_B_S3;
          end else if (last_sym) begin
            state <= S_B_NEXT;
          end else begin
            sidx  <= sidx + SW'(1);
            state <= S_B_S0;
          end
        end
        S_B_S3: begin
          cvia  <= c_rdata;
          state <= S_B_S4;
        end
        S_B_S4: begin
          if (last_sym) begin
            state <= S_B_NEXT;
          end else begin
            sidx  <= sidx + SW'(1);
            state <= S_B_S0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result only follows an accepted end-text item
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc && item.opcode == OP_TEXT_END && built))
    else $error("result without end-text item");

  a_nodes_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= (NW+1)'(MAX_NODES) && nodes_used != '0)
    else $error("node count out of range");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("walk queue read past its tail");

  a_built_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(built) |-> $past(state == S_B_NEXT))
    else $error("built set outside walk end");

endmodule

`default_nettype wire
